// ----- sv/rau_pkg.sv -----
`timescale 1ns / 1ps

package rau_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int OP_W      = 3;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 31;
    localparam int RES_NUM_W = 64;
    localparam int RES_DEN_W = 63;
    localparam int MUL_STEPS = 4;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_LESS    = 3'd4,
        OP_GREATER = 3'd5,
        OP_EQUAL   = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        MS_AN_BD,
        MS_BN_AD,
        MS_AD_BD,
        MS_AN_BN,
        MS_AD_BN
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD_N,
        ACC_ADD_N,
        ACC_SUB_N,
        ACC_LOAD_D
    } acc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_GCD,
        ST_SHIFT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_t     acc;
    } micro_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_t     acc;
        logic     check;
        logic     gcd_step;
        logic     shift;
        logic     div_step;
        logic     fin_arith;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            direct;
        logic            u_zero;
        logic            v_one;
    } status_t;

    function automatic micro_t micro(input logic [OP_W-1:0] op, input logic [1:0] step);
        micro_t m;
        m.mul_sel = MS_AD_BD;
        m.acc     = ACC_NONE;
        case (step)
            2'd0:
            begin
                m.mul_sel = (op == OP_MUL) ? MS_AN_BN : MS_AN_BD;
            end
            2'd1:
            begin
                if (op == OP_MUL)
                    m.mul_sel = MS_AD_BD;
                else if (op == OP_DIV)
                    m.mul_sel = MS_AD_BN;
                else
                    m.mul_sel = MS_BN_AD;
                m.acc = ACC_LOAD_N;
            end
            2'd2:
            begin
                m.mul_sel = MS_AD_BD;
                if (op == OP_ADD)
                    m.acc = ACC_ADD_N;
                else if (op == OP_SUB)
                    m.acc = ACC_SUB_N;
                else
                    m.acc = ACC_LOAD_D;
            end
            default:
            begin
                if (op == OP_ADD || op == OP_SUB)
                    m.acc = ACC_LOAD_D;
            end
        endcase
        return m;
    endfunction

endpackage

// ----- sv/rational_arith_unit.sv -----
// Rational arithmetic unit with greatest-common-divisor reduction.
// Command channel: drive req_type and both fractions with start high; the beat
// is taken at the rising edge where start is high and busy is low. Inputs are
// latched then, so they may change afterwards. busy stays high until the
// result is out.
// Result channel: done is high for exactly one cycle with res_num, res_den,
// cmp_true and div_zero; the receiver must take the beat in that cycle, it
// cannot stall the unit.
// Comparisons, a zero result denominator and the unused code go from the
// multiply steps and the check state straight to done. Arithmetic adds the
// binary GCD loop (one shift or subtract per cycle), an alignment step,
// 2*WIDTH restoring divide steps unless the divisor is one, and a finishing
// step. One item is in flight at a time.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// done; no beat in progress survives it.
`timescale 1ns / 1ps

module rational_arith_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [rau_pkg::OP_W-1:0]             req_type,
    input  logic signed [rau_pkg::NUM_W-1:0]     a_num,
    input  logic [rau_pkg::DEN_W-1:0]            a_den,
    input  logic signed [rau_pkg::NUM_W-1:0]     b_num,
    input  logic [rau_pkg::DEN_W-1:0]            b_den,
    output logic                                 done,
    output logic signed [rau_pkg::RES_NUM_W-1:0] res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]        res_den,
    output logic                                 cmp_true,
    output logic                                 div_zero
);

    rau_pkg::cmd_t    cmd;
    rau_pkg::status_t status;
    logic             start_ok;

    assign start_ok = start && !busy;

    rau_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ok),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rau_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk      (clk),
        .req_type (req_type),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .cmd      (cmd),
        .status   (status),
        .res_num  (res_num),
        .res_den  (res_den),
        .cmp_true (cmp_true),
        .div_zero (div_zero)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work in progress");

    a_div_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_zero) |-> (res_num == '0 && res_den == '0 && !cmp_true))
        else $error("error result carries data");

    a_arith_no_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_den != '0) |-> (!cmp_true && !div_zero))
        else $error("fraction result carries compare or error flag");

endmodule

// ----- sv/rau_ctrl.sv -----
`timescale 1ns / 1ps

module rau_ctrl #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rau_pkg::status_t  status,
    output rau_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done
);

    localparam int MW = 2 * WIDTH;
    localparam int CW = $clog2(MW);
    localparam logic [CW-1:0] DIV_LAST = CW'(MW - 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(rau_pkg::MUL_STEPS - 1);

    rau_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    rau_pkg::micro_t  mop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mop        = rau_pkg::micro(status.op, cnt_reg[1:0]);
        cmd        = '0;
        cmd.mul_sel = mop.mul_sel;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = rau_pkg::ST_MUL;
                end
            end
            rau_pkg::ST_MUL:
            begin
                cmd.acc = mop.acc;
                if (cnt_reg == MUL_LAST)
                    state_next = rau_pkg::ST_CHECK;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            rau_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.direct)
                begin
                    done_next  = 1'b1;
                    state_next = rau_pkg::ST_IDLE;
                end
                else
                    state_next = rau_pkg::ST_GCD;
            end
            rau_pkg::ST_GCD:
            begin
                if (status.u_zero)
                    state_next = rau_pkg::ST_SHIFT;
                else
                    cmd.gcd_step = 1'b1;
            end
            rau_pkg::ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                cnt_next   = '0;
                state_next = status.v_one ? rau_pkg::ST_DONE : rau_pkg::ST_DIV;
            end
            rau_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = rau_pkg::ST_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            rau_pkg::ST_DONE:
            begin
                cmd.fin_arith = 1'b1;
                done_next     = 1'b1;
                state_next    = rau_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != rau_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

// ----- sv/rau_datapath.sv -----
`timescale 1ns / 1ps

module rau_datapath #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic [rau_pkg::OP_W-1:0]             req_type,
    input  logic signed [rau_pkg::NUM_W-1:0]     a_num,
    input  logic [rau_pkg::DEN_W-1:0]            a_den,
    input  logic signed [rau_pkg::NUM_W-1:0]     b_num,
    input  logic [rau_pkg::DEN_W-1:0]            b_den,
    input  rau_pkg::cmd_t                        cmd,
    output rau_pkg::status_t                     status,
    output logic signed [rau_pkg::RES_NUM_W-1:0] res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]        res_den,
    output logic                                 cmp_true,
    output logic                                 div_zero
);

    localparam int MW = 2 * WIDTH;
    localparam int KW = $clog2(MW);

    logic [rau_pkg::OP_W-1:0]             op_reg, op_next;
    logic [WIDTH-1:0]                     an_reg, an_next, bn_reg, bn_next;
    logic [WIDTH-2:0]                     ad_reg, ad_next, bd_reg, bd_next;
    logic signed [MW-1:0]                 prod_reg, prod_next;
    logic signed [MW:0]                   n_reg, n_next, d_reg, d_next;
    logic [MW-1:0]                        u_reg, u_next, v_reg, v_next;
    logic [KW-1:0]                        k_reg, k_next;
    logic [MW-1:0]                        mn_reg, mn_next, md_reg, md_next;
    logic [MW-1:0]                        rn_rem_reg, rn_rem_next, rd_rem_reg, rd_rem_next;
    logic                                 neg_reg, neg_next;
    logic signed [rau_pkg::RES_NUM_W-1:0] res_num_reg, res_num_next;
    logic [rau_pkg::RES_DEN_W-1:0]        res_den_reg, res_den_next;
    logic                                 cmp_reg, cmp_next, dz_reg, dz_next;

    logic signed [WIDTH:0]     mul_a, mul_b;
    logic signed [2*WIDTH+1:0] prod_full;
    logic signed [MW:0]        prod_ext, n_neg, d_neg, q_signed;
    logic [MW-1:0]             n_abs, d_abs;
    logic [MW:0]               uv_diff, vu_diff, trial_n, trial_d, sub_n, sub_d;
    logic                      is_arith, d_zero, cmp_val;

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        prod_reg    <= prod_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        k_reg       <= k_next;
        mn_reg      <= mn_next;
        md_reg      <= md_next;
        rn_rem_reg  <= rn_rem_next;
        rd_rem_reg  <= rd_rem_next;
        neg_reg     <= neg_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        cmp_reg     <= cmp_next;
        dz_reg      <= dz_next;
    end

    always_comb
    begin
        op_next      = op_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        mn_next      = mn_reg;
        md_next      = md_reg;
        rn_rem_next  = rn_rem_reg;
        rd_rem_next  = rd_rem_reg;
        neg_next     = neg_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        cmp_next     = cmp_reg;
        dz_next      = dz_reg;

        if (cmd.load_in)
        begin
            op_next = req_type;
            an_next = a_num[WIDTH-1:0];
            ad_next = a_den[WIDTH-2:0];
            bn_next = b_num[WIDTH-1:0];
            bd_next = b_den[WIDTH-2:0];
        end

        case (cmd.mul_sel)
            rau_pkg::MS_AN_BD:
            begin
                mul_a = {an_reg[WIDTH-1], an_reg};
                mul_b = {2'b00, bd_reg};
            end
            rau_pkg::MS_BN_AD:
            begin
                mul_a = {bn_reg[WIDTH-1], bn_reg};
                mul_b = {2'b00, ad_reg};
            end
            rau_pkg::MS_AN_BN:
            begin
                mul_a = {an_reg[WIDTH-1], an_reg};
                mul_b = {bn_reg[WIDTH-1], bn_reg};
            end
            rau_pkg::MS_AD_BN:
            begin
                mul_a = {2'b00, ad_reg};
                mul_b = {bn_reg[WIDTH-1], bn_reg};
            end
            default:
            begin
                mul_a = {2'b00, ad_reg};
                mul_b = {2'b00, bd_reg};
            end
        endcase
        prod_full = mul_a * mul_b;
        prod_next = prod_full[MW-1:0];
        prod_ext  = {prod_reg[MW-1], prod_reg};

        case (cmd.acc)
            rau_pkg::ACC_LOAD_N: n_next = prod_ext;
            rau_pkg::ACC_ADD_N:  n_next = n_reg + prod_ext;
            rau_pkg::ACC_SUB_N:  n_next = n_reg - prod_ext;
            rau_pkg::ACC_LOAD_D: d_next = prod_ext;
            default:             n_next = n_reg;
        endcase

        n_neg    = -n_reg;
        d_neg    = -d_reg;
        n_abs    = n_reg[MW] ? n_neg[MW-1:0] : n_reg[MW-1:0];
        d_abs    = d_reg[MW] ? d_neg[MW-1:0] : d_reg[MW-1:0];
        is_arith = (op_reg == rau_pkg::OP_ADD) || (op_reg == rau_pkg::OP_SUB) ||
                   (op_reg == rau_pkg::OP_MUL) || (op_reg == rau_pkg::OP_DIV);
        d_zero   = (d_reg == '0);

        case (op_reg)
            rau_pkg::OP_LESS:    cmp_val = (n_reg < d_reg);
            rau_pkg::OP_GREATER: cmp_val = (n_reg > d_reg);
            rau_pkg::OP_EQUAL:   cmp_val = (an_reg == bn_reg) && (ad_reg == bd_reg);
            default:             cmp_val = 1'b0;
        endcase

        if (cmd.check)
        begin
            if (is_arith && !d_zero)
            begin
                u_next   = n_abs;
                v_next   = d_abs;
                mn_next  = n_abs;
                md_next  = d_abs;
                k_next   = '0;
                neg_next = n_reg[MW] ^ d_reg[MW];
            end
            else
            begin
                res_num_next = '0;
                res_den_next = '0;
                cmp_next     = cmp_val;
                dz_next      = is_arith;
            end
        end

        uv_diff = {1'b0, u_reg} - {1'b0, v_reg};
        vu_diff = {1'b0, v_reg} - {1'b0, u_reg};
        if (cmd.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!u_reg[0])
                u_next = u_reg >> 1;
            else if (!v_reg[0])
                v_next = v_reg >> 1;
            else if (!uv_diff[MW])
                u_next = {1'b0, uv_diff[MW-1:1]};
            else
                v_next = {1'b0, vu_diff[MW-1:1]};
        end

        if (cmd.shift)
        begin
            mn_next     = mn_reg >> k_reg;
            md_next     = md_reg >> k_reg;
            rn_rem_next = '0;
            rd_rem_next = '0;
        end

        trial_n = {rn_rem_reg, mn_reg[MW-1]};
        trial_d = {rd_rem_reg, md_reg[MW-1]};
        sub_n   = trial_n - {1'b0, v_reg};
        sub_d   = trial_d - {1'b0, v_reg};
        if (cmd.div_step)
        begin
            rn_rem_next = sub_n[MW] ? trial_n[MW-1:0] : sub_n[MW-1:0];
            rd_rem_next = sub_d[MW] ? trial_d[MW-1:0] : sub_d[MW-1:0];
            mn_next     = {mn_reg[MW-2:0], !sub_n[MW]};
            md_next     = {md_reg[MW-2:0], !sub_d[MW]};
        end

        q_signed = neg_reg ? -$signed({1'b0, mn_reg}) : $signed({1'b0, mn_reg});
        if (cmd.fin_arith)
        begin
            res_num_next = rau_pkg::RES_NUM_W'(q_signed);
            res_den_next = rau_pkg::RES_DEN_W'(md_reg);
            cmp_next     = 1'b0;
            dz_next      = 1'b0;
        end
    end

    assign status.op     = op_reg;
    assign status.direct = !(is_arith && !d_zero);
    assign status.u_zero = (u_reg == '0);
    assign status.v_one  = (v_reg == MW'(1));

    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign cmp_true = cmp_reg;
    assign div_zero = dz_reg;

endmodule
